[rtl/core/kve_pkg.sv]
// kve_pkg: types, constants and character codes shared by the key/value extractor
// used by every module of the extractor, depends on nothing
`default_nettype none

package kve_pkg;

	// default build constants
	localparam int unsigned MAX_KEY_LENGTH_DEF = 16;
	localparam int unsigned QUEUE_DEPTH_DEF    = 4;
	localparam int unsigned CAP_RESET          = 63;

	// configuration register indices
	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_KEY_LEN  = 2'd2;
	localparam logic [1:0] REG_CAPACITY = 2'd3;

	// characters the parser reacts to
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// parser phase
	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_COLON,
		PH_QUOTE,
		PH_COPY,
		PH_DONE
	} phase_t;

	// result kind
	typedef enum logic [1:0] {
		ST_CHAR,
		ST_DONE,
		ST_NOT_FOUND,
		ST_UNTERM
	} status_t;

	// one result word as it travels through the queue
	typedef struct packed {
		logic [7:0] value_char;
		status_t    status;
		logic       truncated;
		logic       last;
	} evt_t;

	// queue flags seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

endpackage

`default_nettype wire

[rtl/core/kve_fifo.sv]
// kve_fifo: small flop-based queue between the parser front and the output stage
// generic, uses kve_pkg only for the flag struct
`default_nettype none

module kve_fifo #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output kve_pkg::q_flags_t     flags
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign flags.full  = (count_q == CNT_W'(DEPTH));
	assign flags.empty = (count_q == '0);
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;
	assign rdata       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/kve_front.sv]
// kve_front: takes message characters, keeps the key window and the parse phase,
// and turns each character into at most one result word; uses kve_pkg
`default_nettype none

module kve_front #(
	parameter int unsigned MAX_KEY_LENGTH = kve_pkg::MAX_KEY_LENGTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    char_in,
	input  wire logic          end_of_message,
	input  wire logic [63:0]   key_bytes_low,
	input  wire logic [63:0]   key_bytes_high,
	input  wire logic [4:0]    key_length,
	input  wire logic [7:0]    value_capacity,
	output logic               evt_valid,
	output kve_pkg::evt_t      evt
);

	localparam int unsigned LEN_W = $clog2(MAX_KEY_LENGTH + 1);
	localparam int unsigned IDX_W = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;

	kve_pkg::phase_t  phase_q, phase_n, phase_eff, phase_mid;
	logic [LEN_W-1:0] seen_q, seen_n, seen_inc;
	logic [7:0]       count_q, count_n;
	logic             ovf_q, ovf_n;
	logic [7:0]       win_q [MAX_KEY_LENGTH];
	logic [7:0]       win_n [MAX_KEY_LENGTH];
	logic [7:0]       key_b [16];
	logic [LEN_W-1:0] len_eff;
	logic             match;
	logic             is_quote;

	// key bytes, first character lowest
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			key_b[j]     = key_bytes_low[8*j +: 8];
			key_b[j + 8] = key_bytes_high[8*j +: 8];
		end
	end

	// key length clipped to the window size
	assign len_eff = (key_length > 5'(MAX_KEY_LENGTH)) ? LEN_W'(MAX_KEY_LENGTH)
	                                                   : LEN_W'(key_length);

	// window after shifting in this character, newest at position 0
	always_comb begin
		win_n[0] = char_in;
		for (int p = 1; p < MAX_KEY_LENGTH; p++) begin
			win_n[p] = win_q[p - 1];
		end
	end

	assign seen_inc = (seen_q < LEN_W'(MAX_KEY_LENGTH)) ? seen_q + LEN_W'(1) : seen_q;

	// last key character against the newest byte, first against the oldest
	always_comb begin
		match = (seen_inc >= len_eff);
		for (int j = 0; j < MAX_KEY_LENGTH; j++) begin
			if (LEN_W'(j) < len_eff) begin
				if (win_n[IDX_W'(len_eff - LEN_W'(j) - LEN_W'(1))] != key_b[j]) begin
					match = 1'b0;
				end
			end
		end
	end

	assign is_quote = (char_in == kve_pkg::CH_DQUOTE) || (char_in == kve_pkg::CH_SQUOTE);

	// next phase and result word
	always_comb begin
		phase_eff = phase_q;
		if (phase_q == kve_pkg::PH_SEARCH && len_eff == '0) begin
			phase_eff = kve_pkg::PH_COLON;
		end
		phase_mid      = phase_eff;
		count_n        = count_q;
		ovf_n          = ovf_q;
		seen_n         = seen_inc;
		evt_valid      = 1'b0;
		evt.value_char = '0;
		evt.status     = kve_pkg::ST_CHAR;
		evt.truncated  = ovf_q;
		evt.last       = 1'b0;

		case (phase_eff)
			kve_pkg::PH_SEARCH: begin
				if (match) begin
					phase_mid = kve_pkg::PH_COLON;
				end
			end
			kve_pkg::PH_COLON: begin
				if (char_in == kve_pkg::CH_COLON) begin
					phase_mid = kve_pkg::PH_QUOTE;
				end
			end
			kve_pkg::PH_QUOTE: begin
				if (is_quote) begin
					phase_mid = kve_pkg::PH_COPY;
				end
			end
			kve_pkg::PH_COPY: begin
				if (is_quote) begin
					phase_mid  = kve_pkg::PH_DONE;
					evt_valid  = 1'b1;
					evt.status = kve_pkg::ST_DONE;
					evt.last   = 1'b1;
				end else if (char_in != kve_pkg::CH_SPACE && !end_of_message) begin
					if (count_q < value_capacity) begin
						count_n        = count_q + 8'd1;
						evt_valid      = 1'b1;
						evt.value_char = char_in;
					end else begin
						ovf_n = 1'b1;
					end
				end else if (char_in != kve_pkg::CH_SPACE && count_q >= value_capacity) begin
					ovf_n = 1'b1;
				end
			end
			default: begin
			end
		endcase

		phase_n = phase_mid;

		// final character of the message
		if (end_of_message) begin
			if (!evt_valid && phase_mid != kve_pkg::PH_DONE) begin
				evt_valid     = 1'b1;
				evt.last      = 1'b1;
				evt.truncated = ovf_n;
				evt.status    = (phase_mid == kve_pkg::PH_SEARCH) ? kve_pkg::ST_NOT_FOUND
				                                                  : kve_pkg::ST_UNTERM;
			end
			phase_n = kve_pkg::PH_SEARCH;
			count_n = '0;
			ovf_n   = 1'b0;
			seen_n  = '0;
		end
	end

	// phase and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kve_pkg::PH_SEARCH;
			seen_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			seen_q  <= seen_n;
			count_q <= count_n;
			ovf_q   <= ovf_n;
		end
	end

	// character window, only read within the bytes seen this message
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int p = 0; p < MAX_KEY_LENGTH; p++) begin
				win_q[p] <= win_n[p];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/kve_back.sv]
// kve_back: output register that drains the result queue onto the master stream
// uses kve_pkg for the result word
`default_nettype none

module kve_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kve_pkg::q_flags_t flags,
	input  wire kve_pkg::evt_t     head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,   // value_char
	output logic [2:0]             m_tuser,   // status[1:0], truncated[2]
	output logic                   m_tlast    // last_of_value
);

	kve_pkg::evt_t out_q;
	logic          valid_q;

	// load when the register is empty or being taken
	assign pop = !flags.empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= !flags.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = out_q.value_char;
	assign m_tuser  = {out_q.truncated, out_q.status};
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

[rtl/core/json_key_value_extractor_top.sv]
// Key/value extractor for JSON-like text.
// Slave stream: one message character per word, s_tdata = char_in, s_tlast marks
// the final character of a message. The block finds the first occurrence of the
// configured key, skips to the next colon and opens the value at the next single
// or double quote; later non-space characters are sent until the closing quote.
// Master stream: m_tdata = value character (zero for other kinds), m_tuser[1:0] =
// kind (0 character, 1 value complete, 2 key not found, 3 unterminated),
// m_tuser[2] = characters were dropped beyond capacity, m_tlast = final word of
// the message. At most one master word per slave word.
// Configuration: cfg_index selects key bytes 0-7, key bytes 8-15, key length,
// value capacity; cfg_ready is always high. Write only while the block is idle.
// Throughput is one character per cycle while s_tready is high; the key window
// compare and the phase logic are combinational in the front. The result is
// written into the queue at the accepting edge and moves on into the output
// register once that register is empty or being taken.
// When the receiver stalls the queue fills and s_tready drops once it is full.
// Reset clears the phase, counters, queue and output valid; capacity resets to 63
// and the key registers to zero.
`default_nettype none

module json_key_value_extractor_top #(
	parameter int unsigned MAX_KEY_LENGTH = kve_pkg::MAX_KEY_LENGTH_DEF,
	parameter int unsigned QUEUE_DEPTH    = kve_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // char_in
	input  wire logic        s_tlast,   // end_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // value_char
	output logic [2:0]       m_tuser,   // status[1:0], truncated[2]
	output logic             m_tlast,   // last_of_value
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int unsigned EVT_W = $bits(kve_pkg::evt_t);

	logic [63:0]       key_low_q;
	logic [63:0]       key_high_q;
	logic [4:0]        key_len_q;
	logic [7:0]        cap_q;
	logic              accept;
	logic              evt_valid;
	kve_pkg::evt_t     evt;
	logic [EVT_W-1:0]  head_bits;
	kve_pkg::q_flags_t q_flags;
	logic              pop;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= '0;
			cap_q      <= 8'(kve_pkg::CAP_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				kve_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				kve_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				kve_pkg::REG_KEY_LEN:  key_len_q  <= cfg_data[4:0];
				kve_pkg::REG_CAPACITY: cap_q      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// a word is taken whenever the queue has room for its result
	assign s_tready = !q_flags.full;
	assign accept   = s_tvalid && s_tready;

	kve_front #(
		.MAX_KEY_LENGTH(MAX_KEY_LENGTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_in       (s_tdata),
		.end_of_message(s_tlast),
		.key_bytes_low (key_low_q),
		.key_bytes_high(key_high_q),
		.key_length    (key_len_q),
		.value_capacity(cap_q),
		.evt_valid     (evt_valid),
		.evt           (evt)
	);

	kve_fifo #(
		.WIDTH(EVT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept && evt_valid),
		.wdata (evt),
		.pop   (pop),
		.rdata (head_bits),
		.flags (q_flags)
	);

	kve_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.flags   (q_flags),
		.head    (kve_pkg::evt_t'(head_bits)),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

[rtl/core/kve_checker.sv]
// kve_checker: port-level checks on the extractor's master stream
// bound to json_key_value_extractor_top, uses kve_pkg for the kind codes
`default_nettype none

module kve_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("master word changed while stalled");

	// every kind other than a value character closes the message
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != kve_pkg::ST_CHAR |-> m_tlast)
		else $error("closing kind without last flag");

	// value characters never close the message
	a_char_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == kve_pkg::ST_CHAR |-> !m_tlast)
		else $error("value character flagged last");

	// non-character kinds carry a zero data byte
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != kve_pkg::ST_CHAR |-> m_tdata == 8'd0)
		else $error("non-zero data on a closing word");

endmodule

bind json_key_value_extractor_top kve_checker u_kve_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
